@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/core/ikcf_pkg.sv @@
package ikcf_pkg;

   localparam int KEY_BYTES   = 8;
   localparam int AVG_SAMPLES = 32;
   localparam int XOR_BYTES   = 4;
   localparam int FRAME_LEN   = KEY_BYTES + XOR_BYTES;

   localparam int SAMPLE_W    = 10;
   localparam int BUTTON_W    = 8;
   localparam int BYTE_W      = 8;
   localparam int KEY_W       = 64;
   localparam int KEY_SEL_W   = 3;
   localparam int CNT_W       = $clog2(AVG_SAMPLES);
   localparam int SUM_W       = SAMPLE_W + CNT_W;
   localparam int LEVEL_SHIFT = 7;
   localparam int IDX_W       = $clog2(FRAME_LEN);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] LEVEL_KEY_ONE  = 8'd225;
   localparam logic [BYTE_W-1:0] LEVEL_KEY_ZERO = 8'd160;
   localparam logic [BYTE_W-1:0] LEVEL_KEY_TWO  = 8'd80;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ZERO  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ONE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_TWO   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_THREE = 2'd3;

   typedef struct packed {
      logic [SAMPLE_W-1:0] adc_sample;
      logic [BUTTON_W-1:0] buttons_n;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] code_byte;
      logic              frame_last;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [BUTTON_W-1:0] button;
   } frame_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
   } queue_stat_type;

   typedef struct packed {
      logic [IDX_W-1:0] byte_idx;
   } back_stat_type;

   function automatic logic [BYTE_W-1:0] key_byte(logic [KEY_W-1:0] key,
                                                  logic [KEY_SEL_W-1:0] sel);
      return key[{sel, 3'b000} +: BYTE_W];
   endfunction

endpackage

@@ rtl/core/ir_key_code_framer.sv @@
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_type: adc_sample, buttons_n
// rsp       out        rsp_valid/rsp_ready  rsp_type: code_byte, frame_last
// csr       in         csr_write_en         csr_index, csr_wdata (64 bits)
//
// One req transaction per cycle; every 32nd closes a group and queues a frame.
// Each frame leaves as KEY_BYTES+4 rsp transactions, one per cycle from the
// output register while rsp_ready stays high. The front stalls only on a
// group-closing sample while the 2-entry frame queue is full. Synchronous
// reset clears the sum, count, keys, queue and the serializer's index and valid.
`include "assert_macros.svh"

module ir_key_code_framer
   import ikcf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_payload
);

   logic           push_valid, push_ready, pop_valid, pop_ready;
   frame_type      push_frame, pop_frame;
   queue_stat_type q_stat;
   back_stat_type  b_stat;

   ikcf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_frame   (push_frame)
   );

   ikcf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_frame (push_frame),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_frame  (pop_frame),
      .stat       (q_stat)
   );

   ikcf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_frame   (pop_frame),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .stat        (b_stat)
   );

   `ASSERT_IMPLIES(a_queue_bound, clock, reset, 1'b1, q_stat.count <= QCNT_W'(QUEUE_DEPTH), "frame queue over depth")
   `ASSERT_IMPLIES(a_last_wraps, clock, reset, rsp_valid && rsp_payload.frame_last, b_stat.byte_idx == '0, "frame index not reset after last byte")
   `ASSERT_NEXT(a_pop_drops, clock, reset, pop_ready && !push_valid && q_stat.count == QCNT_W'(1), !pop_valid, "queue pop left stale entry")

endmodule

@@ rtl/core/ikcf_front.sv @@
module ikcf_front
   import ikcf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_payload,
   output logic                 push_valid,
   input  logic                 push_ready,
   output frame_type            push_frame
);

   logic [KEY_W-1:0]  key_zero_ff, key_one_ff, key_two_ff, key_three_ff;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              group_end;
   logic              take;
   logic [BYTE_W-1:0] level;
   logic [BUTTON_W-1:0] pressed;

   assign group_end  = (cnt_ff == CNT_W'(AVG_SAMPLES - 1));
   assign req_ready  = !group_end || push_ready;
   assign take       = req_valid && req_ready;
   assign push_valid = req_valid && group_end;

   always_comb begin
      sum_in = sum_ff + SUM_W'(req_payload.adc_sample);
      cnt_in = cnt_ff + CNT_W'(1);
      level  = sum_in[LEVEL_SHIFT +: BYTE_W];
      if (level >= LEVEL_KEY_ONE) begin
         push_frame.key = key_one_ff;
      end else if (level >= LEVEL_KEY_ZERO) begin
         push_frame.key = key_zero_ff;
      end else if (level > LEVEL_KEY_TWO) begin
         push_frame.key = key_two_ff;
      end else begin
         push_frame.key = key_three_ff;
      end
      pressed = ~req_payload.buttons_n;
      push_frame.button = pressed & (~pressed + BUTTON_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         cnt_ff       <= '0;
         key_zero_ff  <= '0;
         key_one_ff   <= '0;
         key_two_ff   <= '0;
         key_three_ff <= '0;
      end else begin
         if (take) begin
            sum_ff <= group_end ? '0 : sum_in;
            cnt_ff <= group_end ? '0 : cnt_in;
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_KEY_ZERO:  key_zero_ff  <= csr_wdata;
               CSR_KEY_ONE:   key_one_ff   <= csr_wdata;
               CSR_KEY_TWO:   key_two_ff   <= csr_wdata;
               CSR_KEY_THREE: key_three_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

@@ rtl/core/ikcf_queue.sv @@
module ikcf_queue
   import ikcf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  frame_type      push_frame,
   output logic           pop_valid,
   input  logic           pop_ready,
   output frame_type      pop_frame,
   output queue_stat_type stat
);

   frame_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              push, pop;

   assign push_ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_frame  = entry_ff[rd_ptr_ff];
   assign stat.count = cnt_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - QCNT_W'(1);
         end
      end
   end

endmodule

@@ rtl/core/ikcf_back.sv @@
module ikcf_back
   import ikcf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  frame_type     pop_frame,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_payload,
   output back_stat_type stat
);

   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] xor_idx;
   logic             load, last;

   assign load    = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign last    = (idx_ff == IDX_W'(FRAME_LEN - 1));
   assign pop_ready = load && last;
   assign xor_idx = idx_ff - IDX_W'(KEY_BYTES);

   always_comb begin
      if (idx_ff < IDX_W'(KEY_BYTES)) begin
         rsp_in.code_byte = key_byte(pop_frame.key, idx_ff[KEY_SEL_W-1:0]);
      end else begin
         rsp_in.code_byte = pop_frame.button ^
                            key_byte(pop_frame.key, xor_idx[KEY_SEL_W-1:0]);
      end
      rsp_in.frame_last = last;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            idx_ff       <= last ? '0 : idx_ff + IDX_W'(1);
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = rsp_ff;
   assign stat.byte_idx = idx_ff;

endmodule

@@ verif/tb_ir_key_code_framer.sv @@
module tb_ir_key_code_framer;
   timeunit 1ns;
   timeprecision 1ps;

   import ikcf_pkg::*;

   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 200000;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   logic [KEY_W-1:0]     csr_wdata    = '0;
   logic                 req_valid    = 1'b0;
   logic                 req_ready;
   req_type              req_payload  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready    = 1'b0;
   rsp_type              rsp_payload;

   req_type          sample_queue[$];
   rsp_type          frame_bytes_due[$];
   logic [KEY_W-1:0] key_regs[4];
   logic [SUM_W-1:0] group_sum;
   logic [CNT_W-1:0] group_count;

   int mismatches    = 0;
   int frames_done   = 0;
   int bytes_checked = 0;
   int stall_cycles  = 0;
   int cycles        = 0;
   int key_picks[4];

   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   bit long_hold      = 1'b0;
   int send_gap       = 0;
   int recv_gap       = 0;
   int hold_count     = 0;

   ir_key_code_framer u_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [BYTE_W-1:0] pressed_one_hot(logic [BUTTON_W-1:0] levels_n);
      for (int b = 0; b < BUTTON_W; b++) begin
         if (!levels_n[b]) begin
            return BYTE_W'(1) << b;
         end
      end
      return '0;
   endfunction

   // accumulate one sample; on a group close, queue the whole expected frame
   task automatic take_sample(req_type item);
      logic [BYTE_W-1:0] level;
      logic [BYTE_W-1:0] button;
      logic [KEY_W-1:0]  key;
      int                sel;
      rsp_type           want;
      group_sum = group_sum + SUM_W'(item.adc_sample);
      if (group_count != CNT_W'(AVG_SAMPLES - 1)) begin
         group_count = group_count + 1'b1;
      end else begin
         level = BYTE_W'(group_sum >> LEVEL_SHIFT);
         if (level >= LEVEL_KEY_ONE) begin
            sel = CSR_KEY_ONE;
         end else if (level >= LEVEL_KEY_ZERO) begin
            sel = CSR_KEY_ZERO;
         end else if (level > LEVEL_KEY_TWO) begin
            sel = CSR_KEY_TWO;
         end else begin
            sel = CSR_KEY_THREE;
         end
         key = key_regs[sel];
         key_picks[sel]++;
         button = pressed_one_hot(item.buttons_n);
         for (int i = 0; i < KEY_BYTES; i++) begin
            want.code_byte  = key[BYTE_W*i +: BYTE_W];
            want.frame_last = 1'b0;
            frame_bytes_due.push_back(want);
         end
         for (int i = 0; i < XOR_BYTES; i++) begin
            want.code_byte  = button ^ key[BYTE_W*i +: BYTE_W];
            want.frame_last = (i == XOR_BYTES - 1);
            frame_bytes_due.push_back(want);
         end
         group_sum   = '0;
         group_count = '0;
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0h, want %0h (byte %0d)", what, got, want, bytes_checked);
      mismatches++;
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (req_valid && !req_ready) begin
         stall_cycles <= stall_cycles + 1;
      end else begin
         if (req_valid) begin
            take_sample(req_payload);
         end
         if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (sample_queue.size() == 0) begin
            req_valid <= 1'b0;
         end else if (sender_idles && $urandom_range(0, 6) == 0) begin
            send_gap  <= $urandom_range(0, 17);
            req_valid <= 1'b0;
         end else begin
            req_payload <= sample_queue.pop_front();
            req_valid   <= 1'b1;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
      end else if (long_hold && hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
         rsp_ready  <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap  <= recv_gap - 1;
         rsp_ready <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 6) == 0) begin
         recv_gap  <= $urandom_range(0, 17);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_bytes_due.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_payload.code_byte, 0);
         end else begin
            want = frame_bytes_due.pop_front();
            if (rsp_payload.code_byte !== want.code_byte) begin
               report_mismatch("code_byte", rsp_payload.code_byte, want.code_byte);
            end
            if (rsp_payload.frame_last !== want.frame_last) begin
               report_mismatch("frame_last", rsp_payload.frame_last, want.frame_last);
            end
            bytes_checked++;
            if (want.frame_last) begin
               frames_done++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes still due", cycles,
                  frame_bytes_due.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [KEY_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      key_regs[idx] = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic write_random_keys();
      csr_write(CSR_KEY_ZERO,  {$urandom, $urandom});
      csr_write(CSR_KEY_ONE,   {$urandom, $urandom});
      csr_write(CSR_KEY_TWO,   {$urandom, $urandom});
      csr_write(CSR_KEY_THREE, {$urandom, $urandom});
   endtask

   // one averaging group around base; noise is the percentage of fully random samples
   task automatic queue_group(int base, int spread, int noise, logic [BUTTON_W-1:0] close_n);
      req_type item;
      int      s;
      for (int k = 0; k < AVG_SAMPLES; k++) begin
         if (noise > 0 && $urandom_range(0, 99) < noise) begin
            s = $urandom_range(0, 1023);
         end else begin
            s = base + int'($urandom_range(0, 2 * spread)) - spread;
         end
         if (s < 0) s = 0;
         if (s > 1023) s = 1023;
         item.adc_sample = SAMPLE_W'(s);
         item.buttons_n  = (k == AVG_SAMPLES - 1) ? close_n : BUTTON_W'($urandom_range(0, 255));
         sample_queue.push_back(item);
      end
   endtask

   function automatic logic [BUTTON_W-1:0] random_close();
      case ($urandom_range(0, 3))
         0: begin
            return '1;
         end
         1: begin
            return ~(BUTTON_W'(1) << $urandom_range(0, BUTTON_W - 1));
         end
         default: begin
            return BUTTON_W'($urandom_range(0, 255));
         end
      endcase
   endfunction

   task automatic queue_random_group();
      queue_group($urandom_range(0, 1023), $urandom_range(0, 96), 10, random_close());
   endtask

   // wait until every transaction is through, then let the serializer settle
   task automatic drain();
      while (sample_queue.size() != 0 || req_valid || frame_bytes_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < 4; i++) begin
         key_regs[i]  = '0;
         key_picks[i] = 0;
      end
      group_sum   = '0;
      group_count = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      csr_write(CSR_KEY_ZERO,  64'h0123_4567_89AB_CDEF);
      csr_write(CSR_KEY_ONE,   64'hFEDC_BA98_7654_3210);
      csr_write(CSR_KEY_TWO,   64'h5A5A_A5A5_3C3C_C3C3);
      csr_write(CSR_KEY_THREE, 64'h8000_0000_0000_0001);
      // threshold edges: 225/224, 160/159, 81/80
      queue_group(900, 0, 0, 8'h7F);
      queue_group(899, 0, 0, 8'hF3);
      queue_group(640, 0, 0, 8'hFE);
      queue_group(639, 0, 0, 8'hEF);
      queue_group(324, 0, 0, 8'hBF);
      queue_group(323, 0, 0, 8'hDF);
      drain();

      // output blocked for a long stretch while samples keep coming, no idling
      write_random_keys();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      long_hold      = 1'b1;
      repeat (3) queue_random_group();
      drain();
      long_hold = 1'b0;

      $display("checked %0d frames, %0d bytes; key picks zero/one/two/three: %0d/%0d/%0d/%0d",
               frames_done, bytes_checked, key_picks[CSR_KEY_ZERO], key_picks[CSR_KEY_ONE],
               key_picks[CSR_KEY_TWO], key_picks[CSR_KEY_THREE]);
      $display("input backpressured for %0d cycles, %0d mismatches", stall_cycles, mismatches);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
